// File: src/masked_byte_pattern_scanner_core_assert.svh
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core_assert.svh
// Assertion macros shared by the scanner checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants shared by the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int CFG_DATA_WIDTH     = 64;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int PATTERN_SLOTS      = 16;
    localparam int CARE_WIDTH         = 16;
    localparam int LENGTH_WIDTH       = 5;
    localparam int OFFSET_FIELD_WIDTH = 32;

    localparam logic [CARE_WIDTH-1:0]   CARE_MASK_RESET      = 16'hFFFF;
    localparam logic [LENGTH_WIDTH-1:0] PATTERN_LENGTH_RESET = 5'd16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_CARE_MASK      = 2'd2,
        REG_PATTERN_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_WIDTH-1:0] pattern_bytes_low;
        logic [CFG_DATA_WIDTH-1:0] pattern_bytes_high;
        logic [CARE_WIDTH-1:0]     care_mask;
        logic [LENGTH_WIDTH-1:0]   pattern_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } scan_item_t;

    typedef struct packed {
        logic                          found;
        logic [OFFSET_FIELD_WIDTH-1:0] match_offset;
        logic                          region_done;
    } scan_result_t;

    // Status of the transaction held in the window stage
    typedef struct packed {
        logic valid;
        logic last_byte;
        logic overflow;
    } stage_stat_t;

endpackage

`default_nettype wire

// File: src/mbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file: pattern, care mask and pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cfg_regs
    import mbps_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PATTERN_LOW:    cfg_next.pattern_bytes_low  = cfg_data;
                REG_PATTERN_HIGH:   cfg_next.pattern_bytes_high = cfg_data;
                REG_CARE_MASK:      cfg_next.care_mask      = cfg_data[CARE_WIDTH-1:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[LENGTH_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes_low  <= '0;
            cfg_reg.pattern_bytes_high <= '0;
            cfg_reg.care_mask          <= CARE_MASK_RESET;
            cfg_reg.pattern_length     <= PATTERN_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/mbps_window.sv
// ----------------------------------------------------------------------------
// mbps_window
// Input stage: shifts each accepted byte into the sliding window and counts
// bytes of the region; starts from a clear window after a region's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_window
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int CNT_W       = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic                           advance,
    input  wire scan_item_t                     item,
    output logic [MAX_PATTERN-1:0][7:0]         window,
    output logic [CNT_W-1:0]                    count,
    output stage_stat_t                         stat
);

    logic [MAX_PATTERN-1:0][7:0] window_reg;
    logic [MAX_PATTERN-1:0][7:0] window_next;
    logic [MAX_PATTERN-1:0][7:0] base_window;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            base_count;
    logic                        base_full;
    stage_stat_t                 stat_reg;
    stage_stat_t                 stat_next;

    // Start over after the last byte of a region
    assign base_window = stat_reg.last_byte ? '0 : window_reg;
    assign base_count  = stat_reg.last_byte ? '0 : count_reg;
    assign base_full   = (base_count == {CNT_W{1'b1}});

    // Shift in the new byte, advance the saturating count
    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        stat_next   = stat_reg;
        if (accept)
        begin
            window_next[0] = item.data_byte;
            for (int k = 1; k < MAX_PATTERN; k++)
            begin
                window_next[k] = base_window[k-1];
            end
            count_next          = base_full ? base_count : base_count + CNT_W'(1);
            stat_next.valid     = 1'b1;
            stat_next.last_byte = item.last_byte;
            stat_next.overflow  = base_full;
        end
        else if (advance)
        begin
            stat_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            stat_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            stat_reg   <= stat_next;
        end
    end

    assign window = window_reg;
    assign count  = count_reg;
    assign stat   = stat_reg;

endmodule

`default_nettype wire

// File: src/mbps_match.sv
// ----------------------------------------------------------------------------
// mbps_match
// Result stage: masked compare of the window against the pattern, first-match
// tracking per region, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_match
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int CNT_W       = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cfg_t                           cfg,
    input  wire logic [MAX_PATTERN-1:0][7:0]    window,
    input  wire logic [CNT_W-1:0]               count,
    input  wire stage_stat_t                    stat,
    input  wire logic                           result_stall,
    output logic                                result_valid,
    output scan_result_t                        result,
    output logic                                free
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [PATTERN_SLOTS-1:0][7:0] pattern;
    logic [LEN_W-1:0]              len;
    logic                          window_hit;
    logic                          hit;
    logic                          produce;
    logic                          advance;
    logic [CNT_W-1:0]              offset;
    logic                          reported_reg;
    logic                          reported_next;
    logic                          valid_reg;
    logic                          valid_next;
    scan_result_t                  result_reg;
    scan_result_t                  result_next;

    assign pattern = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

    // Clamp the pattern length into 1..MAX_PATTERN
    always_comb
    begin
        if (cfg.pattern_length == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg.pattern_length > LENGTH_WIDTH'(MAX_PATTERN))
        begin
            len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len = LEN_W'(cfg.pattern_length);
        end
    end

    // Compare each pattern byte against its window byte; wildcards pass
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        logic [7:0]       seen;
        window_hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos  = len - LEN_W'(1) - LEN_W'(i);
            seen = window[pos[IDX_W-1:0]];
            if ((LEN_W'(i) < len) && cfg.care_mask[i] && (seen != pattern[i]))
            begin
                window_hit = 1'b0;
            end
        end
    end

    assign hit     = window_hit && !reported_reg && !stat.overflow
                     && (count >= CNT_W'(len));
    assign produce = hit || (stat.last_byte && !reported_reg);
    assign offset  = count - CNT_W'(len);

    // Output register takes a new result when empty or being drained
    assign free    = !valid_reg || !result_stall;
    assign advance = stat.valid && free;

    always_comb
    begin
        reported_next = reported_reg;
        valid_next    = valid_reg;
        result_next   = result_reg;
        if (advance)
        begin
            reported_next = stat.last_byte ? 1'b0 : (reported_reg || hit);
        end
        if (advance && produce)
        begin
            valid_next               = 1'b1;
            result_next.found        = hit;
            result_next.match_offset = hit ? OFFSET_FIELD_WIDTH'(offset) : '0;
            result_next.region_done  = stat.last_byte;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            reported_reg <= reported_next;
            valid_reg    <= valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: src/masked_byte_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core
// Streams region bytes through a sliding window and reports the first
// masked match of a configured pattern, or not-found at the region's end.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, with no gaps, for as long as results are taken.
// A transaction passes a window register stage and a result register stage:
// its result, if any, is loaded from the window stage into the output
// register once that register is free, and waits there until taken.
// scan_stall rises only while a result sits in the output register and
// result_stall holds it there with another byte already in the window stage.
// At most one result per region: the first match, with its offset from the
// region start, or found = 0 on the last byte; region_done marks a result
// that comes with the last byte. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scanner_core
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN  = 16,
    parameter int OFFSET_WIDTH = 32
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                       scan_valid,
    output logic                            scan_stall,
    input  wire scan_item_t                 scan_item,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output scan_result_t                    result
);

    localparam int CNT_W = (OFFSET_WIDTH < 32) ? OFFSET_WIDTH : 32;

    cfg_t                        cfg;
    logic [MAX_PATTERN-1:0][7:0] window;
    logic [CNT_W-1:0]            count;
    stage_stat_t                 stat;
    logic                        free;
    logic                        accept;
    logic                        advance;

    // Handshake between the two stages
    assign scan_stall = stat.valid && !free;
    assign accept     = scan_valid && !scan_stall;
    assign advance    = stat.valid && free;

    mbps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .advance (advance),
        .item    (scan_item),
        .window  (window),
        .count   (count),
        .stat    (stat)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .window       (window),
        .count        (count),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .free         (free)
    );

endmodule

`default_nettype wire

// File: src/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks on the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_scanner_core_assert.svh"

module mbps_checker
    import mbps_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       scan_valid,
    input  wire logic                       scan_stall,
    input  wire scan_item_t                 scan_item,
    input  wire logic                       result_valid,
    input  wire logic                       result_stall,
    input  wire scan_result_t               result
);

    // Hold a stalled result
    `MBPS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // Not-found only at the end of a region, with a zero offset
    `MBPS_ASSERT_NOW(a_not_found_shape, result_valid && !result.found, result.region_done && (result.match_offset == '0), "bad not-found result")

    // Input backpressure only while a result is held
    `MBPS_ASSERT_NOW(a_stall_cause, scan_stall, result_valid && result_stall, "input stalled without a held result")

    // A new result must come from an accepted transaction
    `MBPS_ASSERT_NOW(a_result_latency, $rose(result_valid), $past(scan_valid && !scan_stall, 2), "result without a matching transaction")

    // Hold a stalled input transaction
    `MBPS_ASSERT_NEXT(a_item_hold, scan_valid && scan_stall, $stable(scan_item), "stalled input changed")

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/masked_byte_pattern_scanner_core_test.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core_test
// Self-checking bench for the masked byte pattern scanner. A directed table
// covers short regions, the length clamps, wildcards and matches on the last
// byte. Random phases then reprogram the pattern, mask and length and stream
// regions that mostly carry the pattern, some with a near miss. Every accepted
// result is checked against a table value or an in-bench scanner model, under
// bursty input and a receiver that stalls on its own schedule.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_core_test
    import mbps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASE_ITEMS   = 150;
    localparam int DRAIN_CYCLES  = 4;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 150;
    localparam int DIRECTED_ROWS = 33;

    // How a table row is used
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_CHECKED,
        ROW_SILENT,
        ROW_KNOWN
    } row_kind_t;

    // Receiver stall behavior
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PULSED
    } stall_mode_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_index_t            reg_index;
        logic [CFG_DATA_WIDTH-1:0] value;
        logic [7:0]            data_byte;
        logic                  last_byte;
        scan_result_t          known;
    } directed_row_t;

    localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // reset settings: a one-byte region is too short to match
        '{ROW_KNOWN,   REG_PATTERN_LOW,    64'd0, 8'h00, 1'b1, '{1'b0, 32'd0, 1'b1}},
        // single byte pattern, then a later match that must stay silent
        '{ROW_WRITE,   REG_PATTERN_LENGTH, 64'd1, 8'h00, 1'b0, '0},
        '{ROW_WRITE,   REG_PATTERN_LOW,    64'hFF, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_KNOWN,   REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '{1'b1, 32'd1, 1'b0}},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b1, '0},
        // length zero acts as one; match on the last byte
        '{ROW_WRITE,   REG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, '0},
        '{ROW_KNOWN,   REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b1, '{1'b1, 32'd0, 1'b1}},
        // oversize length clamps to sixteen, all bytes wildcard
        '{ROW_WRITE,   REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, '0},
        '{ROW_WRITE,   REG_CARE_MASK,      64'd0, 8'h00, 1'b0, '0},
        '{ROW_WRITE,   REG_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, '0},
        '{ROW_SILENT,  REG_PATTERN_LOW,    64'd0, 8'h00, 1'b0, '0},
        '{ROW_KNOWN,   REG_PATTERN_LOW,    64'd0, 8'hFF, 1'b1, '{1'b1, 32'd0, 1'b1}},
        // final pattern byte is a wildcard
        '{ROW_WRITE,   REG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, '0},
        '{ROW_WRITE,   REG_CARE_MASK,      64'h1, 8'h00, 1'b0, '0},
        '{ROW_WRITE,   REG_PATTERN_LOW,    64'h3412, 8'h00, 1'b0, '0},
        '{ROW_CHECKED, REG_PATTERN_LOW,    64'd0, 8'h12, 1'b0, '0},
        '{ROW_CHECKED, REG_PATTERN_LOW,    64'd0, 8'h99, 1'b0, '0},
        '{ROW_CHECKED, REG_PATTERN_LOW,    64'd0, 8'h00, 1'b1, '0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;
    logic                      scan_valid;
    logic                      scan_stall;
    scan_item_t                scan_item;
    logic                      result_valid;
    logic                      result_stall;
    scan_result_t              result;

    // Scanner model: configuration copy and region state
    logic [2*CFG_DATA_WIDTH-1:0] model_pattern;
    logic [CARE_WIDTH-1:0]       model_care;
    logic [LENGTH_WIDTH-1:0]     model_length;
    logic [7:0]                  model_window [PATTERN_SLOTS];
    logic [31:0]                 model_bytes_seen;
    bit                          model_match_reported;

    scan_result_t pending_results [$];
    int           fail_count;
    int           cycle_count;
    int           items_sent;
    int           burst_left;
    int           hold_off_requests;
    int           hold_off_served;
    int           hold_left;
    int           rx_mode_left;
    stall_mode_t  rx_mode;

    masked_byte_pattern_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .scan_item    (scan_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #CLK_HALF clk = ~clk;

    // Pattern length after the clamps to 1..16
    function automatic int unsigned active_length();
        int unsigned len;
        len = 32'(model_length);
        if (len < 1)
            len = 1;
        if (len > PATTERN_SLOTS)
            len = PATTERN_SLOTS;
        return len;
    endfunction

    function automatic logic [7:0] pattern_byte(int unsigned slot);
        return model_pattern[8*slot +: 8];
    endfunction

    function automatic void clear_region_state();
        foreach (model_window[k])
            model_window[k] = 8'h00;
        model_bytes_seen = '0;
        model_match_reported = 1'b0;
    endfunction

    // Shift one byte into the model window; return 1 when a result is due
    function automatic bit predict_scan_result(input logic [7:0] data, input logic last,
                                               output scan_result_t res);
        int unsigned len;
        bit          saturated;
        bit          hit;
        len = active_length();
        saturated = (model_bytes_seen == '1);
        for (int k = PATTERN_SLOTS - 1; k > 0; k--)
            model_window[k] = model_window[k-1];
        model_window[0] = data;
        if (!saturated)
            model_bytes_seen++;
        hit = !model_match_reported && !saturated && (model_bytes_seen >= len);
        for (int unsigned i = 0; i < len; i++)
            if (model_care[i] && model_window[len-1-i] != pattern_byte(i))
                hit = 1'b0;
        res = '0;
        if (hit)
        begin
            res.found = 1'b1;
            res.match_offset = model_bytes_seen - len;
            res.region_done = last;
            model_match_reported = 1'b1;
        end
        else if (last && !model_match_reported)
        begin
            res.region_done = 1'b1;
        end
        if (last)
        begin
            clear_region_state();
            return hit || res.region_done;
        end
        return hit;
    endfunction

    function automatic void report_failure(string what, scan_result_t want, scan_result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected %0b/%0d/%0b, got %0b/%0d/%0b (found/offset/done)",
                     $realtime, what, want.found, want.match_offset, want.region_done,
                     got.found, got.match_offset, got.region_done);
    endfunction

    // Write one register once the scanner has drained
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        scan_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    model_pattern[CFG_DATA_WIDTH-1:0] = value;
            REG_PATTERN_HIGH:   model_pattern[2*CFG_DATA_WIDTH-1:CFG_DATA_WIDTH] = value;
            REG_CARE_MASK:      model_care = value[CARE_WIDTH-1:0];
            REG_PATTERN_LENGTH: model_length = value[LENGTH_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Offer one byte, in bursts with random gaps, and hold it until taken
    task automatic send_byte(input logic [7:0] data, input logic last,
                             input row_kind_t kind, input scan_result_t known);
        scan_result_t res;
        bit           due;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            scan_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(1, 24);
        end
        else
        begin
            @(negedge clk);
        end
        scan_valid <= 1'b1;
        scan_item  <= '{data_byte: data, last_byte: last};
        do
            @(posedge clk);
        while (scan_stall);
        due = predict_scan_result(data, last, res);
        case (kind)
            ROW_KNOWN:   pending_results.push_back(known);
            ROW_CHECKED: if (due) pending_results.push_back(res);
            default: ;
        endcase
        burst_left--;
        items_sent++;
    endtask

    // One region: random bytes, mostly with the pattern planted somewhere
    task automatic scan_region();
        logic [7:0]  region_bytes [$];
        int unsigned region_len;
        int unsigned len;
        int unsigned start;
        int unsigned flip;
        bit          from_pattern;
        region_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                 : $urandom_range(1, 40);
        len = active_length();
        from_pattern = ($urandom_range(0, 4) == 0);
        for (int unsigned k = 0; k < region_len; k++)
            region_bytes.push_back(from_pattern ? pattern_byte($urandom_range(0, 15))
                                                : 8'($urandom));
        if (region_len >= len && $urandom_range(0, 9) < 6)
        begin
            start = $urandom_range(0, region_len - len);
            for (int unsigned k = 0; k < len; k++)
                if (model_care[k])
                    region_bytes[start + k] = pattern_byte(k);
            // near miss: flip one bit of the planted copy
            if ($urandom_range(0, 3) == 0)
            begin
                flip = $urandom_range(0, len - 1);
                region_bytes[start + flip] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        for (int unsigned k = 0; k < region_len; k++)
            send_byte(region_bytes[k], k == region_len - 1, ROW_CHECKED, '0);
    endtask

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (hold_off_served != hold_off_requests)
        begin
            hold_off_served = hold_off_requests;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left <= 0)
        begin
            rx_mode = stall_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_OPEN:   result_stall <= 1'b0;
                RX_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  result_stall <= ($urandom_range(0, 3) != 0);
                RX_PULSED: result_stall <= (cycle_count % 3 == 0);
                default:   result_stall <= 1'b0;
            endcase
        end
    end

    // Check each taken result against the oldest expectation
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_failure("result with none expected", '0, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found || result.match_offset !== want.match_offset
                    || result.region_done !== want.region_done)
                    report_failure("result mismatch", want, result);
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     pending_results.size());
            $display("** masked_byte_pattern_scanner_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        int          phase_end;
        int          random_end;
        logic [15:0] mask;
        logic [4:0]  len_code;
        logic [CFG_DATA_WIDTH-1:0] low_bits;
        logic [CFG_DATA_WIDTH-1:0] high_bits;

        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_PATTERN_LOW;
        cfg_data     = '0;
        scan_valid   = 1'b0;
        scan_item    = '0;
        result_stall = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        items_sent = 0;
        burst_left = 0;
        hold_off_requests = 0;
        hold_off_served = 0;
        hold_left = 0;
        rx_mode_left = 0;
        rx_mode = RX_OPEN;
        model_pattern = '0;
        model_care = CARE_MASK_RESET;
        model_length = PATTERN_LENGTH_RESET;
        clear_region_state();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED_TABLE[r])
        begin
            if (DIRECTED_TABLE[r].kind == ROW_WRITE)
                write_register(DIRECTED_TABLE[r].reg_index, DIRECTED_TABLE[r].value);
            else
                send_byte(DIRECTED_TABLE[r].data_byte, DIRECTED_TABLE[r].last_byte,
                          DIRECTED_TABLE[r].kind, DIRECTED_TABLE[r].known);
        end

        // Random phases, each with fresh settings
        random_end = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_end)
        begin
            case (phase % 6)
                0:       len_code = 5'd1;
                1:       len_code = 5'd16;
                2:       len_code = 5'd0;
                3:       len_code = 5'd31;
                4:       len_code = 5'($urandom_range(17, 30));
                default: len_code = 5'($urandom_range(2, 15));
            endcase
            case (phase % 4)
                0:       mask = 16'hFFFF;
                1:       mask = 16'h0000;
                2:       mask = 16'($urandom);
                default: mask = 16'($urandom) | 16'($urandom);
            endcase
            case (phase)
                0:
                begin
                    low_bits  = '1;
                    high_bits = '1;
                end
                1:
                begin
                    low_bits  = '0;
                    high_bits = '0;
                end
                default:
                begin
                    low_bits  = {$urandom, $urandom};
                    high_bits = {$urandom, $urandom};
                end
            endcase
            // upper data bits of the narrow registers carry noise
            write_register(REG_PATTERN_LOW, low_bits);
            write_register(REG_PATTERN_HIGH, high_bits);
            write_register(REG_CARE_MASK, {$urandom, 16'($urandom), mask});
            write_register(REG_PATTERN_LENGTH, {$urandom, 27'($urandom), len_code});
            if (phase == 3)
            begin
                burst_left = 400;
                hold_off_requests++;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < random_end)
                scan_region();
            phase++;
        end

        // Drain
        @(negedge clk);
        scan_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("** masked_byte_pattern_scanner_core: PASSED **");
        else
            $display("** masked_byte_pattern_scanner_core: FAILED **");
        $finish;
    end

endmodule
